### rtl/core/nbg_pkg.sv
// Shared types, constants and saturating helpers for the n-body step block.
`default_nettype none
package nbg_pkg;
	localparam int NB     = 16;
	localparam int IDX_W  = 4;
	localparam int W      = 48;
	localparam int MA_W   = 72;
	localparam int MB_W   = 49;
	localparam int MP_W   = MA_W + MB_W;
	localparam int D2_W   = 98;
	localparam int RT_W   = D2_W / 2;

	localparam logic [0:0] CMD_LOAD = 1'b0;
	localparam logic [0:0] CMD_STEP = 1'b1;

	localparam logic [1:0] REG_BODY_COUNT    = 2'd0;
	localparam logic [1:0] REG_POSITION_RATE = 2'd1;

	typedef struct packed {
		logic [2:0][W-1:0] pos;
		logic [2:0][W-1:0] vel;
		logic [W-1:0]      mu;
	} body_t;

	typedef struct packed {
		logic             shift;
		logic             wr_load;
		logic             wr_pos;
		logic             wr_vel;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] n_m1;
	} cell_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PLOAD, S_PMUL, S_PMUL_W, S_PWB, S_PAIR, S_SQ, S_SQ_W, S_CHK,
		S_SQRT_W, S_MUE_W, S_QDIV_W, S_VMUL, S_VMUL_W, S_VDIV_W, S_NEXT, S_VWB
	} state_t;

	function automatic logic [MB_W-1:0] mag49(input logic [MB_W-1:0] x);
		return x[MB_W-1] ? MB_W'(-x) : x;
	endfunction

	// a + (neg ? -m : m), clamped to the 48-bit signed range
	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a,
		input logic [MB_W-1:0] m, input logic neg);
		logic signed [W+1:0] b;
		logic signed [W+1:0] s;
		b = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		s = $signed({{2{a[W-1]}}, a}) + b;
		if (s > $signed({2'b00, 1'b0, {(W-1){1'b1}}}))
			return {1'b0, {(W-1){1'b1}}};
		if (s < $signed({2'b11, 1'b1, {(W-1){1'b0}}}))
			return {1'b1, {(W-1){1'b0}}};
		return s[W-1:0];
	endfunction
endpackage
`default_nettype wire

### rtl/core/nbg_cell.sv
// One body cell of the rotating body ring.
`default_nettype none
module nbg_cell (
	input  wire logic                          clk,
	input  wire logic [nbg_pkg::IDX_W-1:0]     cell_idx,
	input  wire nbg_pkg::cell_ctl_t            ctl,
	input  wire nbg_pkg::body_t                wdata,
	input  wire nbg_pkg::body_t                nxt,
	input  wire nbg_pkg::body_t                head,
	output nbg_pkg::body_t                     body
);
	logic in_use;
	logic tail;
	logic sel;
	nbg_pkg::body_t body_q;

	assign in_use = cell_idx <= ctl.n_m1;
	assign tail   = cell_idx == ctl.n_m1;
	assign sel    = cell_idx == ctl.wr_idx;

	// ring wraps at the last body in use; unused cells hold
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (in_use) body_q <= tail ? head : nxt;
		end else if (sel) begin
			if (ctl.wr_load) body_q <= wdata;
			if (ctl.wr_pos) body_q.pos <= wdata.pos;
			if (ctl.wr_vel) body_q.vel <= wdata.vel;
		end
	end

	assign body = body_q;
endmodule
`default_nettype wire

### rtl/core/nbg_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module nbg_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [nbg_pkg::MA_W-1:0]    a,
	input  wire logic [nbg_pkg::MB_W-1:0]    b,
	output logic                             done,
	output logic [nbg_pkg::MP_W-1:0]         prod
);
	logic                        run_q;
	logic [5:0]                  cnt_q;
	logic [nbg_pkg::MP_W-1:0]    a_q;
	logic [nbg_pkg::MB_W-1:0]    b_q;
	logic [nbg_pkg::MP_W-1:0]    acc_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(nbg_pkg::MB_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= nbg_pkg::MP_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[nbg_pkg::MP_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[nbg_pkg::MB_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

### rtl/core/nbg_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nbg_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [nbg_pkg::MP_W-1:0]    num,
	input  wire logic [nbg_pkg::D2_W-1:0]    den,
	output logic                             done,
	output logic [nbg_pkg::MP_W-1:0]         quot
);
	logic                        run_q;
	logic                        done_q;
	logic [6:0]                  cnt_q;
	logic [nbg_pkg::MP_W-1:0]    num_q;
	logic [nbg_pkg::D2_W-1:0]    den_q;
	logic [nbg_pkg::D2_W-1:0]    rem_q;
	logic [nbg_pkg::D2_W:0]      trial;
	logic                        qbit;

	assign trial = {rem_q, num_q[nbg_pkg::MP_W-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(nbg_pkg::MP_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= qbit ? nbg_pkg::D2_W'(trial - {1'b0, den_q})
			              : trial[nbg_pkg::D2_W-1:0];
			num_q <= {num_q[nbg_pkg::MP_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule
`default_nettype wire

### rtl/core/nbg_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module nbg_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [nbg_pkg::D2_W-1:0]    rad,
	output logic                             done,
	output logic [nbg_pkg::RT_W-1:0]         root
);
	logic                        run_q;
	logic                        done_q;
	logic [5:0]                  cnt_q;
	logic [nbg_pkg::D2_W-1:0]    rad_q;
	logic [nbg_pkg::RT_W+1:0]    rem_q;
	logic [nbg_pkg::RT_W-1:0]    root_q;
	logic [nbg_pkg::RT_W+3:0]    t_rem;
	logic [nbg_pkg::RT_W+3:0]    t_try;
	logic                        fits;

	assign t_rem = {rem_q, rad_q[nbg_pkg::D2_W-1 -: 2]};
	assign t_try = (nbg_pkg::RT_W+4)'({root_q, 2'b01});
	assign fits  = t_rem >= t_try;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(nbg_pkg::RT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[nbg_pkg::D2_W-3:0], 2'b00};
			rem_q  <= fits ? (nbg_pkg::RT_W+2)'(t_rem - t_try)
			               : t_rem[nbg_pkg::RT_W+1:0];
			root_q <= {root_q[nbg_pkg::RT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

### rtl/core/n_body_gravity_step.sv
// Top level: body ring, step sequencer and shared multiply, divide and root units.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  command | start / busy          | cmd, body_index, load_*, elapsed
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//  result  | out_valid (strobe)    | out_index, out_pos_*, out_vel_*, last_body
//
// A load beat leaves busy low. A step beat over n bodies keeps busy high while, per body, the
// position advances (3 products on the shift-add multiplier), each full pair runs squares,
// root, mu*elapsed, divide and a multiply and divide per component, the self pair and a
// coincident pair skip the force, and the velocity is written back; each result strobes once,
// the cycle after write-back, and the receiver cannot stall it. Reset idles the sequencer;
// bodies are undefined until loaded.
`default_nettype none
module n_body_gravity_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               cmd,
	input  wire logic [3:0]         body_index,
	input  wire logic signed [47:0] load_pos_x,
	input  wire logic signed [47:0] load_pos_y,
	input  wire logic signed [47:0] load_pos_z,
	input  wire logic signed [47:0] load_vel_x,
	input  wire logic signed [47:0] load_vel_y,
	input  wire logic signed [47:0] load_vel_z,
	input  wire logic [47:0]        load_mu,
	input  wire logic [23:0]        elapsed,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    out_valid,
	output logic [3:0]              out_index,
	output logic signed [47:0]      out_pos_x,
	output logic signed [47:0]      out_pos_y,
	output logic signed [47:0]      out_pos_z,
	output logic signed [47:0]      out_vel_x,
	output logic signed [47:0]      out_vel_y,
	output logic signed [47:0]      out_vel_z,
	output logic                    last_body
);
	nbg_pkg::state_t state_q, state_d;

	logic [4:0]  body_count_q;
	logic [15:0] position_rate_q;
	logic [3:0]  n_m1;

	logic [3:0]  i_q, j_q;
	logic [1:0]  c_q;
	logic [39:0] k_q;
	logic [23:0] el_q;
	logic [2:0][47:0] pi_q, vi_q;
	logic [2:0][48:0] dl_q;
	logic [nbg_pkg::D2_W-1:0] d2_q;
	logic [nbg_pkg::RT_W-1:0] d_q;
	logic [nbg_pkg::MA_W-1:0] q_q;

	logic accept;
	logic out_valid_q, last_q;
	logic [3:0] out_index_q;
	logic [2:0][47:0] out_pos_q, out_vel_q;

	// ring
	nbg_pkg::body_t    cell_q [nbg_pkg::NB];
	nbg_pkg::body_t    wdata;
	nbg_pkg::cell_ctl_t ctl;
	nbg_pkg::body_t    cur;

	// shared units
	logic mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
	logic [nbg_pkg::MA_W-1:0] mul_a;
	logic [nbg_pkg::MB_W-1:0] mul_b;
	logic [nbg_pkg::MP_W-1:0] mul_p, div_num, div_q;
	logic [nbg_pkg::D2_W-1:0] div_den;
	logic [nbg_pkg::RT_W-1:0] root;
	logic [nbg_pkg::MB_W-1:0] dmag, vmag, clip;

	assign accept    = start && !busy;
	assign busy      = state_q != nbg_pkg::S_IDLE;
	assign cfg_ready = 1'b1;

	// clamp body_count to 1..NB
	always_comb begin
		if (body_count_q == 5'd0)
			n_m1 = 4'd0;
		else if (body_count_q >= 5'(nbg_pkg::NB))
			n_m1 = 4'(nbg_pkg::NB - 1);
		else
			n_m1 = 4'(body_count_q - 5'd1);
	end

	genvar k;
	generate
		for (k = 0; k < nbg_pkg::NB; k++) begin : g_cell
			nbg_cell u_cell (
				.clk      (clk),
				.cell_idx (4'(k)),
				.ctl      (ctl),
				.wdata    (wdata),
				.nxt      (cell_q[(k + 1) % nbg_pkg::NB]),
				.head     (cell_q[0]),
				.body     (cell_q[k])
			);
		end
	endgenerate

	assign cur  = cell_q[i_q];
	assign dmag = nbg_pkg::mag49(dl_q[c_q]);
	assign vmag = nbg_pkg::mag49({vi_q[c_q][47], vi_q[c_q]});

	// quotient clipped to 2^48
	assign clip = ((|div_q[nbg_pkg::MP_W-1:49]) || (div_q[48] && |div_q[47:0]))
	            ? {1'b1, 48'd0} : div_q[48:0];

	nbg_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);
	nbg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_q)
	);
	nbg_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .rad(d2_q),
		.done(sqrt_done), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nbg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, unit starts and ring control
	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		mul_a      = q_q;
		mul_b      = dmag;
		div_num    = mul_p;
		div_den    = nbg_pkg::D2_W'({d_q, 16'd0});
		ctl.shift   = 1'b0;
		ctl.wr_load = 1'b0;
		ctl.wr_pos  = 1'b0;
		ctl.wr_vel  = 1'b0;
		ctl.wr_idx  = i_q;
		ctl.n_m1    = n_m1;
		wdata.pos = pi_q;
		wdata.vel = vi_q;
		wdata.mu  = load_mu;
		unique case (state_q)
			nbg_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd == nbg_pkg::CMD_STEP) begin
						state_d = nbg_pkg::S_PLOAD;
					end else begin
						ctl.wr_load = 1'b1;
						ctl.wr_idx  = body_index;
						wdata.pos   = {load_pos_z, load_pos_y, load_pos_x};
						wdata.vel   = {load_vel_z, load_vel_y, load_vel_x};
					end
				end
			end
			nbg_pkg::S_PLOAD: state_d = nbg_pkg::S_PMUL;
			nbg_pkg::S_PMUL: begin
				mul_start = 1'b1;
				mul_a     = nbg_pkg::MA_W'(k_q);
				mul_b     = vmag;
				state_d   = nbg_pkg::S_PMUL_W;
			end
			nbg_pkg::S_PMUL_W: begin
				if (mul_done) state_d = (c_q == 2'd2) ? nbg_pkg::S_PWB : nbg_pkg::S_PMUL;
			end
			nbg_pkg::S_PWB: begin
				ctl.wr_pos = 1'b1;
				state_d    = nbg_pkg::S_PAIR;
			end
			nbg_pkg::S_PAIR: state_d = (j_q == i_q) ? nbg_pkg::S_NEXT : nbg_pkg::S_SQ;
			nbg_pkg::S_SQ: begin
				mul_start = 1'b1;
				mul_a     = nbg_pkg::MA_W'(dmag);
				state_d   = nbg_pkg::S_SQ_W;
			end
			nbg_pkg::S_SQ_W: begin
				if (mul_done) state_d = (c_q == 2'd2) ? nbg_pkg::S_CHK : nbg_pkg::S_SQ;
			end
			nbg_pkg::S_CHK: begin
				if (d2_q == '0) begin
					state_d = nbg_pkg::S_NEXT;
				end else begin
					sqrt_start = 1'b1;
					state_d    = nbg_pkg::S_SQRT_W;
				end
			end
			nbg_pkg::S_SQRT_W: begin
				mul_a = nbg_pkg::MA_W'(cell_q[0].mu);
				mul_b = nbg_pkg::MB_W'(el_q);
				if (sqrt_done) begin
					mul_start = 1'b1;
					state_d   = nbg_pkg::S_MUE_W;
				end
			end
			nbg_pkg::S_MUE_W: begin
				div_den = d2_q;
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = nbg_pkg::S_QDIV_W;
				end
			end
			nbg_pkg::S_QDIV_W: begin
				if (div_done) state_d = nbg_pkg::S_VMUL;
			end
			nbg_pkg::S_VMUL: begin
				mul_start = 1'b1;
				state_d   = nbg_pkg::S_VMUL_W;
			end
			nbg_pkg::S_VMUL_W: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = nbg_pkg::S_VDIV_W;
				end
			end
			nbg_pkg::S_VDIV_W: begin
				if (div_done) state_d = (c_q == 2'd2) ? nbg_pkg::S_NEXT : nbg_pkg::S_VMUL;
			end
			nbg_pkg::S_NEXT: begin
				ctl.shift = 1'b1;
				state_d   = (j_q == n_m1) ? nbg_pkg::S_VWB : nbg_pkg::S_PAIR;
			end
			nbg_pkg::S_VWB: begin
				ctl.wr_vel = 1'b1;
				state_d    = (i_q == n_m1) ? nbg_pkg::S_IDLE : nbg_pkg::S_PLOAD;
			end
			default: state_d = nbg_pkg::S_IDLE;
		endcase
	end

	// configuration registers, result strobe and body counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_count_q    <= 5'd2;
			position_rate_q <= 16'd655;
			out_valid_q     <= 1'b0;
			i_q             <= '0;
		end else begin
			out_valid_q <= state_q == nbg_pkg::S_VWB;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					nbg_pkg::REG_BODY_COUNT:    body_count_q    <= cfg_data[4:0];
					nbg_pkg::REG_POSITION_RATE: position_rate_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == nbg_pkg::S_VWB) i_q <= (i_q == n_m1) ? 4'd0 : i_q + 4'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			nbg_pkg::S_IDLE: begin
				k_q  <= position_rate_q * elapsed;
				el_q <= elapsed;
			end
			nbg_pkg::S_PLOAD: begin
				pi_q <= cur.pos;
				vi_q <= cur.vel;
				c_q  <= 2'd0;
			end
			nbg_pkg::S_PMUL_W: begin
				if (mul_done) begin
					pi_q[c_q] <= nbg_pkg::sat_add(pi_q[c_q], {1'b0, mul_p[87:40]},
						vi_q[c_q][47]);
					c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
				end
			end
			nbg_pkg::S_PWB: j_q <= 4'd0;
			nbg_pkg::S_PAIR: begin
				for (int c = 0; c < 3; c++)
					dl_q[c] <= {cell_q[0].pos[c][47], cell_q[0].pos[c]}
					         - {pi_q[c][47], pi_q[c]};
				c_q  <= 2'd0;
				d2_q <= '0;
			end
			nbg_pkg::S_SQ_W: begin
				if (mul_done) begin
					d2_q <= d2_q + mul_p[nbg_pkg::D2_W-1:0];
					c_q  <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
				end
			end
			nbg_pkg::S_SQRT_W: if (sqrt_done) d_q <= root;
			nbg_pkg::S_QDIV_W: if (div_done) q_q <= div_q[nbg_pkg::MA_W-1:0];
			nbg_pkg::S_VDIV_W: begin
				if (div_done) begin
					vi_q[c_q] <= nbg_pkg::sat_add(vi_q[c_q], clip, dl_q[c_q][48]);
					c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
				end
			end
			nbg_pkg::S_NEXT: j_q <= j_q + 4'd1;
			nbg_pkg::S_VWB: begin
				out_index_q <= i_q;
				out_pos_q   <= pi_q;
				out_vel_q   <= vi_q;
				last_q      <= i_q == n_m1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_pos_x = out_pos_q[0];
	assign out_pos_y = out_pos_q[1];
	assign out_pos_z = out_pos_q[2];
	assign out_vel_x = out_vel_q[0];
	assign out_vel_y = out_vel_q[1];
	assign out_vel_z = out_vel_q[2];
	assign last_body = last_q;

	// a step beat always leaves idle
	a_step_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == nbg_pkg::CMD_STEP) |=> busy)
		else $error("step beat did not start the sequencer");

	// only the final body may appear after the sequencer has gone idle
	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_body) |-> busy)
		else $error("non-final result after step end");

	// no two result strobes are back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid)
		else $error("back-to-back result strobes");

	// body counter is rewound whenever idle
	a_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nbg_pkg::S_IDLE) |-> (i_q == 4'd0))
		else $error("body counter not rewound at idle");
endmodule
`default_nettype wire

### test/n_body_gravity_step_test.sv
// Self-checking bench for the n-body gravity step block: body-table predictor and result checks.
`default_nettype none

typedef struct {
	logic        cmd;
	logic [3:0]  idx;
	logic [47:0] pos [3];
	logic [47:0] vel [3];
	logic [47:0] mu;
	logic [23:0] el;
} gravity_beat_t;

typedef struct {
	logic [3:0]  idx;
	logic [47:0] pos [3];
	logic [47:0] vel [3];
	logic        last;
} body_report_t;

class gravity_board;
	localparam longint PMAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint PMIN = -64'sh8000_0000_0000;

	longint            body_pos [16][3];
	longint            body_vel [16][3];
	logic [47:0]       body_mu [16];
	logic [4:0]        count_reg;
	logic [15:0]       rate_reg;
	body_report_t      expected_bodies [$];
	int                errors;

	function new();
		count_reg = 5'd2;
		rate_reg  = 16'd655;
		errors    = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [15:0] data);
		if (idx == nbg_pkg::REG_BODY_COUNT) count_reg = data[4:0];
		else if (idx == nbg_pkg::REG_POSITION_RATE) rate_reg = data;
	endfunction

	static function longint sat(longint a, longint b);
		longint s;
		s = a + b;
		if (s > PMAX) return PMAX;
		if (s < PMIN) return PMIN;
		return s;
	endfunction

	static function logic [63:0] mag(longint x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	static function logic [63:0] root_floor(logic [127:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 50; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= v) r = c;
		end
		return r;
	endfunction

	// one accepted beat: a load updates the table, a step queues n reports
	function void note_beat(gravity_beat_t it);
		int           n;
		logic [63:0]  k;
		logic [127:0] m, d2, q, den, r;
		logic [63:0]  d;
		longint       dl [3];
		body_report_t rep;
		if (it.cmd == nbg_pkg::CMD_LOAD) begin
			for (int c = 0; c < 3; c++) begin
				body_pos[it.idx][c] = longint'($signed(it.pos[c]));
				body_vel[it.idx][c] = longint'($signed(it.vel[c]));
			end
			body_mu[it.idx] = it.mu;
			return;
		end
		n = count_reg == 0 ? 1 : (count_reg > 16 ? 16 : count_reg);
		k = 64'(rate_reg) * 64'(it.el);
		for (int i = 0; i < n; i++) begin
			// position advance, truncated toward zero
			for (int c = 0; c < 3; c++) begin
				m = 128'(mag(body_vel[i][c])) * 128'(k);
				m = m >> 40;
				body_pos[i][c] = sat(body_pos[i][c],
					body_vel[i][c] < 0 ? -longint'(m) : longint'(m));
			end
			// pull from every other body, coincident pairs skipped
			for (int j = 0; j < n; j++) begin
				if (j == i) continue;
				d2 = 0;
				for (int c = 0; c < 3; c++) begin
					dl[c] = body_pos[j][c] - body_pos[i][c];
					d2 += 128'(mag(dl[c])) * 128'(mag(dl[c]));
				end
				if (d2 == 0) continue;
				d   = root_floor(d2);
				q   = (128'(body_mu[j]) * 128'(it.el)) / d2;
				den = 128'(d) << 16;
				for (int c = 0; c < 3; c++) begin
					r = (q * 128'(mag(dl[c]))) / den;
					if (r > (128'd1 << 48)) r = 128'd1 << 48;
					body_vel[i][c] = sat(body_vel[i][c],
						dl[c] < 0 ? -longint'(r) : longint'(r));
				end
			end
			rep.idx = 4'(i);
			for (int c = 0; c < 3; c++) begin
				rep.pos[c] = body_pos[i][c][47:0];
				rep.vel[c] = body_vel[i][c][47:0];
			end
			rep.last = (i + 1 == n);
			expected_bodies.push_back(rep);
		end
	endfunction

	function void check_body(body_report_t got);
		body_report_t exp;
		if (expected_bodies.size() == 0) begin
			$display("%t unexpected body report idx %0d", $realtime, got.idx);
			errors++;
			return;
		end
		exp = expected_bodies.pop_front();
		if (got.idx !== exp.idx) begin
			$display("%t out_index exp %0d got %0d", $realtime, exp.idx, got.idx);
			errors++;
		end
		for (int c = 0; c < 3; c++) begin
			if (got.pos[c] !== exp.pos[c]) begin
				$display("%t body %0d pos[%0d] exp %h got %h", $realtime, exp.idx, c,
					exp.pos[c], got.pos[c]);
				errors++;
			end
			if (got.vel[c] !== exp.vel[c]) begin
				$display("%t body %0d vel[%0d] exp %h got %h", $realtime, exp.idx, c,
					exp.vel[c], got.vel[c]);
				errors++;
			end
		end
		if (got.last !== exp.last) begin
			$display("%t body %0d last_body exp %b got %b", $realtime, exp.idx,
				exp.last, got.last);
			errors++;
		end
	endfunction
endclass

module n_body_gravity_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               cmd = 1'b0;
	logic [3:0]         body_index = '0;
	logic signed [47:0] load_pos_x = '0, load_pos_y = '0, load_pos_z = '0;
	logic signed [47:0] load_vel_x = '0, load_vel_y = '0, load_vel_z = '0;
	logic [47:0]        load_mu = '0;
	logic [23:0]        elapsed = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               out_valid;
	logic [3:0]         out_index;
	logic signed [47:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [47:0] out_vel_x, out_vel_y, out_vel_z;
	logic               last_body;

	gravity_board board = new();
	bit           burst;

	n_body_gravity_step u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results are strobed for one cycle; sample before the edge's updates land
	always @(posedge clk) begin
		body_report_t got;
		if (arst_n && out_valid) begin
			got.idx  = out_index;
			got.pos  = '{out_pos_x, out_pos_y, out_pos_z};
			got.vel  = '{out_vel_x, out_vel_y, out_vel_z};
			got.last = last_body;
			board.check_body(got);
		end
	end

	// hard stop well past the slowest legal run, even with every beat a sixteen-body step
	initial begin
		#5s;
		$display("status: fail");
		$finish;
	end

	function automatic logic [47:0] any48();
		return 48'({$urandom, $urandom});
	endfunction

	// plausible coordinate: whole part within +/-span, random fraction
	function automatic logic [47:0] near(int span);
		longint w;
		w = longint'($urandom_range(0, 2 * span)) - span;
		return 48'((w <<< 16) + $urandom_range(0, 65535));
	endfunction

	function automatic gravity_beat_t make_load(logic [3:0] idx, bit wild);
		gravity_beat_t it;
		it.cmd = nbg_pkg::CMD_LOAD;
		it.idx = idx;
		for (int c = 0; c < 3; c++) begin
			it.pos[c] = wild ? any48() : near(400);
			it.vel[c] = wild ? any48() : near(8);
		end
		it.mu = wild ? any48() : 48'({$urandom} << $urandom_range(0, 16));
		it.el = 24'($urandom);
		return it;
	endfunction

	function automatic gravity_beat_t make_step(logic [23:0] el);
		gravity_beat_t it;
		it     = make_load(4'($urandom), 1);
		it.cmd = nbg_pkg::CMD_STEP;
		it.el  = el;
		return it;
	endfunction

	// one command beat; start is left high so back-to-back beats need no gap
	task automatic send(gravity_beat_t it);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		cmd        <= it.cmd;
		body_index <= it.idx;
		load_pos_x <= it.pos[0];
		load_pos_y <= it.pos[1];
		load_pos_z <= it.pos[2];
		load_vel_x <= it.vel[0];
		load_vel_y <= it.vel[1];
		load_vel_z <= it.vel[2];
		load_mu    <= it.mu;
		elapsed    <= it.el;
		do @(posedge clk); while (busy);
		board.note_beat(it);
	endtask

	// sender holds off until every report is in and the sequencer is idle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.expected_bodies.size() != 0);
		repeat (30) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		gravity_beat_t it;
		int            counts [6];
		logic [15:0]   rates [6];
		counts = '{1, 2, 3, 4, 0, 2};
		rates = '{16'd0, 16'hFFFF, 16'd655, 16'($urandom), 16'($urandom), 16'($urandom)};
		burst = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table first so no step ever reads an unloaded body
		for (int b = 0; b < 16; b++) begin
			it = make_load(4'(b), 0);
			case (b)
			0: begin
				// field extremes
				it.pos = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF};
				it.vel = '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h0};
				it.mu  = 48'hFFFF_FFFF_FFFF;
			end
			1, 2: begin
				// coincident and at rest: zero-distance pair
				it.pos = '{48'h0001_0000_0000, 48'h0, 48'hFFFF_0000_0000};
				it.vel = '{48'h0, 48'h0, 48'h0};
			end
			3: it.mu = 48'h0;
			default: ;
			endcase
			send(it);
		end

		// reset settings: two bodies, default rate
		send(make_step(24'h0));
		send(make_step(24'hFF_FFFF));
		drain();
		// count above the table size saturates to all sixteen bodies
		write_reg(nbg_pkg::REG_BODY_COUNT, 16'd31);
		write_reg(nbg_pkg::REG_POSITION_RATE, 16'hFFFF);
		write_reg(2'd3, 16'($urandom));
		send(make_step(24'($urandom)));
		drain();

		// random phases: mostly well-formed bodies, some raw bit noise
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(nbg_pkg::REG_BODY_COUNT, 16'(counts[ph]));
			write_reg(nbg_pkg::REG_POSITION_RATE, rates[ph]);
			for (int n = 0; n < 69; n++) begin
				if (n % 10 == 0) burst = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0)
					send(make_step($urandom_range(0, 1) ? 24'($urandom) :
						24'($urandom_range(0, 4095))));
				else
					send(make_load(4'($urandom), $urandom_range(0, 3) == 0));
			end
			drain();
		end

		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

`default_nettype wire
